// ----- sv/tlwta_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlwta_pkg
// Shared widths, request codes and lane control type for the two-layer
// winner-take-all network.
// ----------------------------------------------------------------------------
package tlwta_pkg;

   localparam int NUM_INPUTS           = 5;
   localparam int NUM_HIDDEN_DEFAULT   = 8;
   localparam int NUM_OUTPUTS_DEFAULT  = 3;

   localparam int IN_W     = 8;    // one network input, unsigned integer
   localparam int WEIGHT_W = 16;   // Q8.8 weight
   localparam int INDEX_W  = 6;    // flat weight index
   localparam int HID_W    = 32;   // hidden sum, Q.8
   localparam int OUT_W    = 48;   // output sum, Q.16
   localparam int ONODE_W  = 3;    // output node number

   // One row of the input-to-hidden store: the inputs plus the bias input.
   localparam int IH_ROW   = NUM_INPUTS + 1;
   // Hidden lanes multiply a zero-extended input by a weight.
   localparam int HOP_W    = IN_W + 1;
   localparam int HACC_W   = HOP_W + WEIGHT_W + $clog2(IH_ROW);

   // The hidden bias is 1.0 in Q.8.
   localparam int HID_BIAS = 256;

   typedef enum logic [1:0] {
      ACT_LOAD_IH = 2'd0,
      ACT_LOAD_HO = 2'd1,
      ACT_EVAL    = 2'd2
   } action_type;

   typedef struct packed {
      logic issue;   // a weight read and a product start this cycle
      logic first;   // this product starts a new sum
   } lane_ctrl_type;

endpackage

// ----- sv/tlwta_channels.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlwta channels
// Valid/ready channels for requests, results and the control register.
// ----------------------------------------------------------------------------
interface tlwta_req_if;
   logic                                       valid;
   logic                                       ready;
   logic [1:0]                                 action;
   logic [tlwta_pkg::INDEX_W-1:0]              weight_index;
   logic signed [tlwta_pkg::WEIGHT_W-1:0]      weight_value;
   logic [tlwta_pkg::IN_W-1:0]                 food_ahead;
   logic [tlwta_pkg::IN_W-1:0]                 food_left;
   logic [tlwta_pkg::IN_W-1:0]                 food_right;
   logic [tlwta_pkg::IN_W-1:0]                 food_straight_ahead;
   logic [tlwta_pkg::IN_W-1:0]                 food_left_total;

   modport source (
      output valid, action, weight_index, weight_value, food_ahead, food_left,
             food_right, food_straight_ahead, food_left_total,
      input  ready
   );
   modport sink (
      input  valid, action, weight_index, weight_value, food_ahead, food_left,
             food_right, food_straight_ahead, food_left_total,
      output ready
   );
endinterface

interface tlwta_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [tlwta_pkg::ONODE_W-1:0]         output_index;
   logic signed [tlwta_pkg::OUT_W-1:0]    output_value;
   logic                                  last;

   modport source (output valid, output_index, output_value, last, input ready);
   modport sink   (input valid, output_index, output_value, last, output ready);
endinterface

interface tlwta_csr_if;
   logic valid;
   logic ready;
   logic winner_take_all;

   modport source (output valid, winner_take_all, input ready);
   modport sink   (input valid, winner_take_all, output ready);
endinterface

// ----- sv/two_layer_net_winner_take_all.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_layer_net_winner_take_all
// Two-layer linear network in fixed point with an optional winner-take-all
// stage on the outputs.
// ----------------------------------------------------------------------------
// Load requests (action 0 or 1) write one Q8.8 weight into the input-to-hidden
// or hidden-to-output store in the cycle they are accepted; an index past the
// store's size is dropped, and a load request produces no result. An evaluate
// request (action 2) runs the five inputs plus a bias of one through
// NUM_HIDDEN hidden lanes that work side by side, one weight each per cycle,
// then runs the hidden sums plus a bias of 1.0 through NUM_OUTPUTS output lanes
// the same way, and finally a merge stage scans the output sums for the first
// strict maximum and returns one result per output node in node order, with
// last set on the final one. With winner_take_all set, every node but the
// winner reads zero. The control register must only be written while no
// evaluation is in flight. Rate: load requests are taken one per cycle while
// no evaluation is in flight. An evaluate request holds the request side until
// the merge stage has issued its last result; the hidden and output phases
// each step through one row of weights in the lanes' read-multiply-accumulate
// pipeline, and the merge stage compares one output sum per cycle and then
// sends one result per cycle while results are taken. Result back-pressure
// only stretches the last phase.
// Weights must be written before they are used; the stores are not cleared.
// ----------------------------------------------------------------------------
module two_layer_net_winner_take_all #(
   parameter int NUM_HIDDEN  = tlwta_pkg::NUM_HIDDEN_DEFAULT,
   parameter int NUM_OUTPUTS = tlwta_pkg::NUM_OUTPUTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   tlwta_req_if.sink   req_if,
   tlwta_rsp_if.source rsp_if,
   tlwta_csr_if.sink   csr_if
);

   localparam int IH_ROW  = tlwta_pkg::IH_ROW;
   localparam int HO_ROW  = NUM_HIDDEN + 1;
   localparam int IH_AW   = $clog2(IH_ROW);
   localparam int HO_AW   = $clog2(HO_ROW);
   localparam int HOP_W   = tlwta_pkg::HOP_W;
   localparam int HACC_W  = tlwta_pkg::HACC_W;
   localparam int HID_W   = tlwta_pkg::HID_W;
   localparam int OUT_W   = tlwta_pkg::OUT_W;
   localparam int OACC_W  = HID_W + tlwta_pkg::WEIGHT_W + $clog2(HO_ROW);
   localparam int MAX_ROW = (IH_ROW > HO_ROW) ? IH_ROW : HO_ROW;
   // A phase issues one weight per step and then waits for the lane pipeline.
   localparam int STEP_W  = $clog2(MAX_ROW + 3);
   localparam int IH_SPAN = NUM_HIDDEN * IH_ROW;
   localparam int HO_SPAN = NUM_OUTPUTS * HO_ROW;
   localparam int WSPAN   = (IH_SPAN > HO_SPAN) ? IH_SPAN : HO_SPAN;
   localparam int WIDX_W  = $clog2(((WSPAN > 64) ? WSPAN : 64) + 1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_HID   = 4'b0010,
      S_OUT   = 4'b0100,
      S_MERGE = 4'b1000
   } state_type;

   state_type                     state_ff, state_in;
   logic [STEP_W-1:0]             step_ff, step_in;
   logic                          wta_ff, wta_in;
   logic [tlwta_pkg::IN_W-1:0]    x_ff [tlwta_pkg::NUM_INPUTS];

   logic                          req_take;
   logic                          eval_take;
   logic                          ih_load;
   logic                          ho_load;
   logic [WIDX_W-1:0]             widx;
   logic                          merge_start;
   logic                          merge_done;

   tlwta_pkg::lane_ctrl_type      hid_ctrl;
   tlwta_pkg::lane_ctrl_type      out_ctrl;
   logic [IH_AW-1:0]              ih_addr;
   logic [HO_AW-1:0]              ho_addr;
   logic signed [HOP_W-1:0]       hid_ops [IH_ROW];
   logic signed [HOP_W-1:0]       hid_op;
   logic signed [HID_W-1:0]       hid_vals [HO_ROW];
   logic signed [HID_W-1:0]       out_op;
   logic signed [HACC_W-1:0]      hid_acc [NUM_HIDDEN];
   logic signed [OACC_W-1:0]      out_acc [NUM_OUTPUTS];
   logic signed [OUT_W-1:0]       res [NUM_OUTPUTS];

   // Request side: one request at a time, loads finish in their own cycle.
   assign req_if.ready = (state_ff == S_IDLE);
   assign csr_if.ready = 1'b1;
   assign req_take     = req_if.valid && req_if.ready;
   assign eval_take    = req_take && (req_if.action == tlwta_pkg::ACT_EVAL);
   assign ih_load      = req_take && (req_if.action == tlwta_pkg::ACT_LOAD_IH);
   assign ho_load      = req_take && (req_if.action == tlwta_pkg::ACT_LOAD_HO);
   assign widx         = WIDX_W'(req_if.weight_index);

   assign wta_in = (csr_if.valid && csr_if.ready) ? csr_if.winner_take_all : wta_ff;

   // Sequencer: hidden phase, output phase, then hand over to the merge stage.
   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      merge_start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (eval_take) begin
               state_in = S_HID;
               step_in  = '0;
            end
         end
         S_HID: begin
            if (step_ff == STEP_W'(IH_ROW + 1)) begin
               state_in = S_OUT;
               step_in  = '0;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         S_OUT: begin
            // The merge stage reads the sums in this cycle, so the last product
            // must already be in the accumulators.
            if (step_ff == STEP_W'(HO_ROW + 2)) begin
               state_in    = S_MERGE;
               step_in     = '0;
               merge_start = 1'b1;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         S_MERGE: begin
            if (merge_done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         wta_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         wta_ff   <= wta_in;
      end
      if (eval_take) begin
         x_ff[0] <= req_if.food_ahead;
         x_ff[1] <= req_if.food_left;
         x_ff[2] <= req_if.food_right;
         x_ff[3] <= req_if.food_straight_ahead;
         x_ff[4] <= req_if.food_left_total;
      end
   end

   // Hidden phase control. The last operand of the row is the bias input of one.
   always_comb begin
      hid_ctrl.issue = (state_ff == S_HID) && (step_ff < STEP_W'(IH_ROW));
      hid_ctrl.first = (step_ff == '0);
      ih_addr        = hid_ctrl.issue ? IH_AW'(step_ff) : '0;
      for (int i = 0; i < tlwta_pkg::NUM_INPUTS; i++) begin
         hid_ops[i] = signed'({1'b0, x_ff[i]});
      end
      hid_ops[IH_ROW-1] = HOP_W'(1);
      hid_op            = hid_ops[ih_addr];
   end

   // Hidden sums cannot leave 32 bits here, so they only need sign extension.
   // The extra row entry is the hidden bias of 1.0 in Q.8.
   always_comb begin
      out_ctrl.issue = (state_ff == S_OUT) && (step_ff < STEP_W'(HO_ROW));
      out_ctrl.first = (step_ff == '0);
      ho_addr        = out_ctrl.issue ? HO_AW'(step_ff) : '0;
      for (int h = 0; h < NUM_HIDDEN; h++) begin
         hid_vals[h] = HID_W'(hid_acc[h]);
      end
      hid_vals[HO_ROW-1] = HID_W'(tlwta_pkg::HID_BIAS);
      out_op             = hid_vals[ho_addr];
   end

   // Each hidden lane owns one row of the input-to-hidden store.
   for (genvar h = 0; h < NUM_HIDDEN; h++) begin : g_hid
      localparam int BASE = h * IH_ROW;
      logic             hit;
      logic [IH_AW-1:0] waddr;

      assign hit   = ih_load && (widx >= WIDX_W'(BASE)) && (widx < WIDX_W'(BASE + IH_ROW));
      assign waddr = IH_AW'(widx - WIDX_W'(BASE));

      tlwta_lane #(
         .OP_W  (HOP_W),
         .DEPTH (IH_ROW),
         .ACC_W (HACC_W)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .wr_en   (hit),
         .wr_addr (waddr),
         .wr_data (req_if.weight_value),
         .ctrl    (hid_ctrl),
         .rd_addr (ih_addr),
         .operand (hid_op),
         .acc     (hid_acc[h])
      );
   end

   // Each output lane owns one row of the hidden-to-output store and saturates
   // its exact Q.16 sum to 48 bits.
   for (genvar o = 0; o < NUM_OUTPUTS; o++) begin : g_out
      localparam int BASE = o * HO_ROW;
      logic                      hit;
      logic [HO_AW-1:0]          waddr;
      logic [OACC_W-OUT_W:0]     top_bits;
      logic                      in_range;

      assign hit   = ho_load && (widx >= WIDX_W'(BASE)) && (widx < WIDX_W'(BASE + HO_ROW));
      assign waddr = HO_AW'(widx - WIDX_W'(BASE));

      tlwta_lane #(
         .OP_W  (HID_W),
         .DEPTH (HO_ROW),
         .ACC_W (OACC_W)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .wr_en   (hit),
         .wr_addr (waddr),
         .wr_data (req_if.weight_value),
         .ctrl    (out_ctrl),
         .rd_addr (ho_addr),
         .operand (out_op),
         .acc     (out_acc[o])
      );

      assign top_bits = out_acc[o][OACC_W-1:OUT_W-1];
      assign in_range = (&top_bits) || !(|top_bits);
      assign res[o]   = in_range ? out_acc[o][OUT_W-1:0] :
                        (out_acc[o][OACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                              : {1'b0, {(OUT_W-1){1'b1}}});
   end

   tlwta_merge #(
      .NUM_OUTPUTS (NUM_OUTPUTS)
   ) u_merge (
      .clock  (clock),
      .reset  (reset),
      .start  (merge_start),
      .wta    (wta_ff),
      .res    (res),
      .done   (merge_done),
      .rsp_if (rsp_if)
   );

   // An evaluate request always starts the hidden phase in the next cycle.
   a_eval_starts: assert property (@(posedge clock) disable iff (reset)
      eval_take |=> state_ff == S_HID)
      else $error("evaluate request did not start the hidden phase");

   // Weight stores are never written while an evaluation reads them.
   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      (ih_load || ho_load) |-> !hid_ctrl.issue && !out_ctrl.issue)
      else $error("weight write during an evaluation");

   // The merge stage finishes only while the sequencer waits for it.
   a_done_in_merge: assert property (@(posedge clock) disable iff (reset)
      merge_done |-> state_ff == S_MERGE)
      else $error("merge finished outside the merge phase");

   // The flagged final result always belongs to the last output node.
   a_last_node: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.last) |->
         rsp_if.output_index == tlwta_pkg::ONODE_W'(NUM_OUTPUTS - 1))
      else $error("last result carries the wrong node");

endmodule

// ----- sv/tlwta_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlwta_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tlwta_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/tlwta_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlwta_lane
// One multiply-accumulate lane with its own weight store: read, multiply and
// accumulate stages lie between an issue and the updated sum.
// ----------------------------------------------------------------------------
module tlwta_lane #(
   parameter int OP_W  = tlwta_pkg::HOP_W,
   parameter int DEPTH = tlwta_pkg::IH_ROW,
   parameter int ACC_W = tlwta_pkg::HACC_W
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   wr_en,
   input  logic [$clog2(DEPTH)-1:0]               wr_addr,
   input  logic signed [tlwta_pkg::WEIGHT_W-1:0]  wr_data,
   input  tlwta_pkg::lane_ctrl_type               ctrl,
   input  logic [$clog2(DEPTH)-1:0]               rd_addr,
   input  logic signed [OP_W-1:0]                 operand,
   output logic signed [ACC_W-1:0]                acc
);

   localparam int PROD_W = OP_W + tlwta_pkg::WEIGHT_W;

   logic [tlwta_pkg::WEIGHT_W-1:0]        rd_data;
   logic signed [tlwta_pkg::WEIGHT_W-1:0] weight;
   logic signed [OP_W-1:0]                op_ff;
   logic signed [PROD_W-1:0]              prod_ff;
   logic signed [ACC_W-1:0]               acc_ff;
   logic signed [ACC_W-1:0]               acc_in;
   logic                                  v1_ff;
   logic                                  v2_ff;
   logic                                  first1_ff;
   logic                                  first2_ff;

   tlwta_ram #(
      .WIDTH (tlwta_pkg::WEIGHT_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign weight = signed'(rd_data);

   always_comb begin
      acc_in = acc_ff;
      if (v2_ff) begin
         acc_in = first2_ff ? ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= ctrl.issue;
         v2_ff <= v1_ff;
      end
      first1_ff <= ctrl.first;
      first2_ff <= first1_ff;
      op_ff     <= operand;
      prod_ff   <= op_ff * weight;
      acc_ff    <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ----- sv/tlwta_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlwta_merge
// Finds the first strict maximum of the output sums and sends one result per
// output node through a registered output stage.
// ----------------------------------------------------------------------------
module tlwta_merge #(
   parameter int NUM_OUTPUTS = tlwta_pkg::NUM_OUTPUTS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                wta,
   input  logic signed [tlwta_pkg::OUT_W-1:0]  res [NUM_OUTPUTS],
   output logic                                done,
   tlwta_rsp_if.source                         rsp_if
);

   localparam int SEL_W = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
   localparam logic [SEL_W-1:0] LAST_SEL = SEL_W'(NUM_OUTPUTS - 1);

   typedef enum logic [2:0] {
      M_IDLE = 3'b001,
      M_SCAN = 3'b010,
      M_EMIT = 3'b100
   } mstate_type;

   mstate_type                          mstate_ff, mstate_in;
   logic [SEL_W-1:0]                    sel_ff, sel_in;
   logic [SEL_W-1:0]                    best_ff, best_in;
   logic signed [tlwta_pkg::OUT_W-1:0]  best_val_ff, best_val_in;
   logic                                out_valid_ff, out_valid_in;
   logic [tlwta_pkg::ONODE_W-1:0]       out_index_ff, out_index_in;
   logic signed [tlwta_pkg::OUT_W-1:0]  out_value_ff, out_value_in;
   logic                                out_last_ff, out_last_in;
   logic signed [tlwta_pkg::OUT_W-1:0]  cur;
   logic                                load;

   assign cur  = res[sel_ff];
   assign load = !out_valid_ff || rsp_if.ready;

   always_comb begin
      mstate_in    = mstate_ff;
      sel_in       = sel_ff;
      best_in      = best_ff;
      best_val_in  = best_val_ff;
      out_valid_in = out_valid_ff && !rsp_if.ready;
      out_index_in = out_index_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      done         = 1'b0;
      unique case (mstate_ff)
         M_IDLE: begin
            if (start) begin
               best_in     = '0;
               best_val_in = res[0];
               if (NUM_OUTPUTS > 1) begin
                  sel_in    = SEL_W'(1);
                  mstate_in = M_SCAN;
               end else begin
                  sel_in    = '0;
                  mstate_in = M_EMIT;
               end
            end
         end
         M_SCAN: begin
            // Strictly greater only, so an equal later sum leaves the earlier one.
            if (cur > best_val_ff) begin
               best_in     = sel_ff;
               best_val_in = cur;
            end
            if (sel_ff == LAST_SEL) begin
               sel_in    = '0;
               mstate_in = M_EMIT;
            end else begin
               sel_in = sel_ff + SEL_W'(1);
            end
         end
         M_EMIT: begin
            if (load) begin
               out_valid_in = 1'b1;
               out_index_in = tlwta_pkg::ONODE_W'(sel_ff);
               out_value_in = (!wta || sel_ff == best_ff) ? cur : '0;
               out_last_in  = (sel_ff == LAST_SEL);
               if (sel_ff == LAST_SEL) begin
                  mstate_in = M_IDLE;
                  done      = 1'b1;
               end else begin
                  sel_in = sel_ff + SEL_W'(1);
               end
            end
         end
         default: begin
            mstate_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mstate_ff    <= M_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         mstate_ff    <= mstate_in;
         out_valid_ff <= out_valid_in;
      end
      sel_ff       <= sel_in;
      best_ff      <= best_in;
      best_val_ff  <= best_val_in;
      out_index_ff <= out_index_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.output_index = out_index_ff;
   assign rsp_if.output_value = out_value_ff;
   assign rsp_if.last         = out_last_ff;

endmodule
